// File: src/pse_pkg.sv
// shared types and constants for the property-list string extractor
`timescale 1ns / 1ps
package pse_pkg;

  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned LEN_BITS_DEF   = 16;
  localparam int unsigned MAX_RES        = 5;
  localparam int unsigned QDEPTH         = 4;
  localparam int unsigned QAW            = 2;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_MAGIC     = 4'd1;
  localparam logic [3:0] ST_ARR_MARK  = 4'd2;
  localparam logic [3:0] ST_ARR_LEN   = 4'd3;
  localparam logic [3:0] ST_STR_MARK  = 4'd4;
  localparam logic [3:0] ST_STR_LEN   = 4'd5;
  localparam logic [3:0] ST_TRUNC     = 4'd6;
  localparam logic [3:0] ST_SURR      = 4'd7;
  localparam logic [3:0] ST_TOO_LARGE = 4'd8;

  // one output transaction
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       tag_end;
    logic       blob_done;
    logic [3:0] status;
    logic       run_last;
  } res_t;

  // work item between front and back: a code point (or raw byte) to emit
  typedef struct packed {
    logic        has_cp;    // emit utf-8 of cp
    logic        raw;       // emit cp[7:0] unchanged as one byte
    logic [20:0] cp;
    logic        fin;       // finish tag after cp
    logic        done;      // blob end result
    logic [3:0]  status;
  } work_t;

  function automatic logic [7:0] magic_byte(input logic [2:0] i);
    logic [7:0] r;
    unique case (i)
      3'd0: r = 8'h62;
      3'd1: r = 8'h70;
      3'd2: r = 8'h6C;
      3'd3: r = 8'h69;
      3'd4: r = 8'h73;
      3'd5: r = 8'h74;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// File: src/pse_front.sv
// front end: parses blob bytes and produces one work item per input byte
`timescale 1ns / 1ps
module pse_front #(
  parameter int unsigned COUNT_BITS = pse_pkg::COUNT_BITS_DEF,
  parameter int unsigned LEN_BITS   = pse_pkg::LEN_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_take,
  input  logic [7:0]      in_byte,
  input  logic            blob_last,
  output logic            wk_valid,
  output pse_pkg::work_t  wk
);
  import pse_pkg::*;

  localparam int unsigned CW = (COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS;

  typedef enum logic [12:0] {
    PH_MAGIC = 13'b0000000000001,
    PH_VER   = 13'b0000000000010,
    PH_ARR   = 13'b0000000000100,
    PH_AEXT  = 13'b0000000001000,
    PH_ALEN  = 13'b0000000010000,
    PH_SKIP  = 13'b0000000100000,
    PH_SMARK = 13'b0000001000000,
    PH_SEXT  = 13'b0000010000000,
    PH_SLEN  = 13'b0000100000000,
    PH_BODY  = 13'b0001000000000,
    PH_DROP  = 13'b0010000000000,
    PH_DONE  = 13'b0100000000000,
    PH_ERR   = 13'b1000000000000
  } phase_t;

  phase_t        phase_r, phase_nxt;
  logic [2:0]    bcnt_r, bcnt_nxt;
  logic [CW-1:0] strings_r, strings_nxt;
  logic [CW-1:0] units_r, units_nxt;
  logic [CW-1:0] acc_r, acc_nxt;
  logic [3:0]    lbl_r, lbl_nxt;
  logic          wide_r, wide_nxt;
  logic [7:0]    uhi_r, uhi_nxt;
  logic [9:0]    phs_r, phs_nxt;
  logic          sw_r, sw_nxt;
  logic [3:0]    err_r, err_nxt;

  logic [3:0]  hi, lo;
  logic [15:0] u;
  logic        fin;
  logic        has_cp;
  logic        raw;
  logic [20:0] cp;
  logic [CW+7:0] accw;
  logic [CW-1:0] lim;

  assign hi   = in_byte[7:4];
  assign lo   = in_byte[3:0];
  assign u    = {uhi_r, in_byte};
  assign accw = {acc_r, in_byte};

  always_comb begin
    phase_nxt = phase_r; bcnt_nxt = bcnt_r; strings_nxt = strings_r;
    units_nxt = units_r; acc_nxt = acc_r; lbl_nxt = lbl_r; wide_nxt = wide_r;
    uhi_nxt = uhi_r; phs_nxt = phs_r; sw_nxt = sw_r; err_nxt = err_r;
    fin = 1'b0; has_cp = 1'b0; raw = 1'b0; cp = '0;
    lim = (phase_r == PH_ALEN) ? CW'({COUNT_BITS{1'b1}}) : CW'({LEN_BITS{1'b1}});
    unique case (phase_r)
      PH_MAGIC: begin
        if (in_byte != magic_byte(bcnt_r)) begin
          err_nxt = ST_MAGIC; phase_nxt = PH_ERR;
        end else if (bcnt_r == 3'd5) begin
          phase_nxt = PH_VER; bcnt_nxt = '0;
        end else bcnt_nxt = bcnt_r + 3'd1;
      end
      PH_VER: begin
        if (bcnt_r == 3'd1) begin
          phase_nxt = PH_ARR; bcnt_nxt = '0;
        end else bcnt_nxt = 3'd1;
      end
      PH_ARR: begin
        if (hi != 4'hA) begin
          err_nxt = ST_ARR_MARK; phase_nxt = PH_ERR;
        end else if (lo == 4'hF) phase_nxt = PH_AEXT;
        else begin
          strings_nxt = CW'(lo); units_nxt = CW'(lo);
          phase_nxt = (lo != 0) ? PH_SKIP : PH_DONE;
        end
      end
      PH_AEXT, PH_SEXT: begin
        if (hi != 4'h1) begin
          err_nxt = (phase_r == PH_AEXT) ? ST_ARR_LEN : ST_STR_LEN; phase_nxt = PH_ERR;
        end else if (lo > 4'd3) begin
          err_nxt = ST_TOO_LARGE; phase_nxt = PH_ERR;
        end else begin
          lbl_nxt = 4'(4'd1 << lo[1:0]); acc_nxt = '0;
          phase_nxt = (phase_r == PH_AEXT) ? PH_ALEN : PH_SLEN;
        end
      end
      PH_ALEN, PH_SLEN: begin
        // overflow if any bit above the limit is set
        if ((accw[CW+7:CW] != 8'd0) || (accw[CW-1:0] > lim)) begin
          err_nxt = ST_TOO_LARGE; phase_nxt = PH_ERR;
        end else begin
          acc_nxt = accw[CW-1:0];
          lbl_nxt = lbl_r - 4'd1;
          if (lbl_r == 4'd1) begin
            if (phase_r == PH_ALEN) begin
              strings_nxt = accw[CW-1:0]; units_nxt = accw[CW-1:0];
              phase_nxt = (accw[CW-1:0] != 0) ? PH_SKIP : PH_DONE;
            end else begin
              units_nxt = accw[CW-1:0]; bcnt_nxt = '0; sw_nxt = 1'b0; phs_nxt = '0;
              if (accw[CW-1:0] == 0) fin = 1'b1;
              else phase_nxt = PH_BODY;
            end
          end
        end
      end
      PH_SKIP: begin
        units_nxt = units_r - CW'(1);
        if (units_r == CW'(1)) phase_nxt = PH_SMARK;
      end
      PH_SMARK: begin
        if (hi != 4'h5 && hi != 4'h6) begin
          err_nxt = ST_STR_MARK; phase_nxt = PH_ERR;
        end else begin
          wide_nxt = (hi == 4'h6);
          if (lo == 4'hF) phase_nxt = PH_SEXT;
          else begin
            units_nxt = CW'(lo); bcnt_nxt = '0; sw_nxt = 1'b0; phs_nxt = '0;
            if (lo == 0) fin = 1'b1;
            else phase_nxt = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        if (!wide_r) begin
          if (units_r == CW'(2) && in_byte == 8'h0A) begin
            phase_nxt = PH_DROP; bcnt_nxt = '0;
          end else begin
            // ascii strings pass bytes through as is, except that a newline as the second-to-last unit drops the rest
            has_cp = 1'b1; raw = 1'b1; cp = 21'(in_byte);
            units_nxt = units_r - CW'(1);
            if (units_r == CW'(1)) fin = 1'b1;
          end
        end else if (bcnt_r == 3'd0) begin
          uhi_nxt = in_byte; bcnt_nxt = 3'd1;
        end else begin
          bcnt_nxt = '0;
          if (units_r == CW'(2) && u == 16'h000A) begin
            if (sw_r) begin
              err_nxt = ST_SURR; phase_nxt = PH_ERR;
            end else phase_nxt = PH_DROP;
          end else if (sw_r && !(u >= 16'hDC00 && u <= 16'hDFFF)) begin
            err_nxt = ST_SURR; phase_nxt = PH_ERR;
          end else if (!sw_r && u >= 16'hDC00 && u <= 16'hDFFF) begin
            err_nxt = ST_SURR; phase_nxt = PH_ERR;
          end else begin
            if (sw_r) begin
              has_cp = 1'b1;
              cp = 21'h10000 + {1'b0, phs_r, u[9:0]};
              sw_nxt = 1'b0;
            end else if (u >= 16'hD800 && u <= 16'hDBFF) begin
              phs_nxt = u[9:0]; sw_nxt = 1'b1;
            end else begin
              has_cp = 1'b1; cp = 21'(u);
            end
            units_nxt = units_r - CW'(1);
            if (units_r == CW'(1)) begin
              if (sw_nxt) begin
                err_nxt = ST_SURR; phase_nxt = PH_ERR;
              end else fin = 1'b1;
            end
          end
        end
      end
      PH_DROP: begin
        if (wide_r && bcnt_r == 3'd0) bcnt_nxt = 3'd1;
        else fin = 1'b1;
      end
      PH_DONE, PH_ERR: ;
      default: ;
    endcase
    if (fin) begin
      strings_nxt = strings_r - CW'(1);
      phase_nxt = (strings_r != CW'(1)) ? PH_SMARK : PH_DONE;
      bcnt_nxt = '0;
    end
  end

  always_comb begin
    wk_valid    = in_take;
    wk.has_cp   = has_cp;
    wk.raw      = raw;
    wk.cp       = cp;
    wk.fin      = fin;
    wk.done     = blob_last;
    wk.status   = (err_nxt != ST_OK) ? err_nxt : ((phase_nxt == PH_DONE) ? ST_OK : ST_TRUNC);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (in_take && blob_last)) begin
      phase_r <= PH_MAGIC; bcnt_r <= '0; strings_r <= '0; units_r <= '0;
      acc_r <= '0; lbl_r <= '0; wide_r <= 1'b0; uhi_r <= '0; phs_r <= '0;
      sw_r <= 1'b0; err_r <= ST_OK;
    end else if (in_take) begin
      phase_r <= phase_nxt; bcnt_r <= bcnt_nxt; strings_r <= strings_nxt;
      units_r <= units_nxt; acc_r <= acc_nxt; lbl_r <= lbl_nxt; wide_r <= wide_nxt;
      uhi_r <= uhi_nxt; phs_r <= phs_nxt; sw_r <= sw_nxt; err_r <= err_nxt;
    end
  end

endmodule

// File: src/pse_queue.sv
// short fifo of work items between front and back
`timescale 1ns / 1ps
module pse_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr,
  input  pse_pkg::work_t  wdata,
  output logic            full,
  input  logic            rd,
  output logic            nempty,
  output pse_pkg::work_t  rdata
);
  import pse_pkg::*;

  work_t         mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r;

  assign full   = (cnt_r == (QAW+1)'(QDEPTH));
  assign nempty = (cnt_r != '0);
  assign rdata  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QAW+1)'(wr) - (QAW+1)'(rd);
    end
  end

endmodule

// File: src/pse_back.sv
// back end: expands work items into utf-8 result transactions
`timescale 1ns / 1ps
module pse_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wk_nempty,
  input  pse_pkg::work_t  wk,
  output logic            wk_rd,
  output logic            out_empty,
  input  logic            out_pop,
  output pse_pkg::res_t   res
);
  import pse_pkg::*;

  res_t        list [MAX_RES];
  logic [2:0]  n;
  logic [2:0]  idx_r;
  logic        ov_r;
  res_t        ob_r;
  logic        take_res;
  logic        adv;
  res_t        cur;

  always_comb begin
    for (int i = 0; i < MAX_RES; i++) list[i] = '0;
    n = '0;
    if (wk.has_cp) begin
      if (wk.raw || wk.cp < 21'h80) begin
        list[0].out_byte = wk.cp[7:0]; n = 3'd1;
      end else if (wk.cp < 21'h800) begin
        list[0].out_byte = {3'b110, wk.cp[10:6]};
        list[1].out_byte = {2'b10, wk.cp[5:0]}; n = 3'd2;
      end else if (wk.cp < 21'h10000) begin
        list[0].out_byte = {4'b1110, wk.cp[15:12]};
        list[1].out_byte = {2'b10, wk.cp[11:6]};
        list[2].out_byte = {2'b10, wk.cp[5:0]}; n = 3'd3;
      end else begin
        list[0].out_byte = {5'b11110, wk.cp[20:18]};
        list[1].out_byte = {2'b10, wk.cp[17:12]};
        list[2].out_byte = {2'b10, wk.cp[11:6]};
        list[3].out_byte = {2'b10, wk.cp[5:0]}; n = 3'd4;
      end
      for (int i = 0; i < 4; i++) list[i].byte_valid = (3'(i) < n);
    end
    if (wk.fin) begin
      if (n == 0) n = 3'd1;
      list[n-3'd1].tag_end = 1'b1;
    end
    if (wk.done) begin
      list[n].blob_done = 1'b1;
      list[n].status    = wk.status;
      n = n + 3'd1;
    end
    if (n != 0) list[n-3'd1].run_last = 1'b1;
  end

  // one result per cycle from the head item into the output register, unless that register is held unpopped
  assign take_res = !ov_r || out_pop;
  assign cur      = list[idx_r];
  assign adv      = wk_nempty && take_res;
  assign wk_rd    = wk_nempty && (n == 0 || (take_res && idx_r + 3'd1 >= n));
  assign out_empty = !ov_r;
  assign res       = ob_r;

  always_ff @(posedge clk) begin
    if (adv && n != 0) ob_r <= cur;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0; idx_r <= '0;
    end else begin
      if (adv && n != 0) ov_r <= 1'b1;
      else if (out_pop) ov_r <= 1'b0;
      if (wk_rd) idx_r <= '0;
      else if (adv) idx_r <= idx_r + 3'd1;
    end
  end

endmodule

// File: src/plist_string_array_extractor_top.sv
// top level of the property-list string extractor
// path: the results of a byte pass through the work queue and then the output register
// throughput: one byte per cycle unless full; one result per cycle unless the output
// register is held unpopped, up to five per byte, bursts absorbed by a four-entry work queue
// reset: synchronous active-low rst_n clears parser state, queue pointers and output valid flag
`timescale 1ns / 1ps
module plist_string_array_extractor_top #(
  parameter int unsigned COUNT_BITS = pse_pkg::COUNT_BITS_DEF,
  parameter int unsigned LEN_BITS   = pse_pkg::LEN_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_blob_last,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_tag_end,
  output logic       out_blob_done,
  output logic [3:0] out_status,
  output logic       out_run_last
);
  import pse_pkg::*;

  logic  take, wk_valid, q_nempty, q_rd;
  work_t wk, qd;
  res_t  res;

  assign take = push && !full;

  pse_front #(.COUNT_BITS(COUNT_BITS), .LEN_BITS(LEN_BITS)) u_front (
    .clk, .rst_n, .in_take(take), .in_byte, .blob_last(in_blob_last),
    .wk_valid, .wk
  );

  pse_queue u_queue (
    .clk, .rst_n, .wr(wk_valid), .wdata(wk), .full,
    .rd(q_rd), .nempty(q_nempty), .rdata(qd)
  );

  pse_back u_back (
    .clk, .rst_n, .wk_nempty(q_nempty), .wk(qd), .wk_rd(q_rd),
    .out_empty(empty), .out_pop(pop), .res
  );

  assign out_byte       = res.out_byte;
  assign out_byte_valid = res.byte_valid;
  assign out_tag_end    = res.tag_end;
  assign out_blob_done  = res.blob_done;
  assign out_status     = res.status;
  assign out_run_last   = res.run_last;

`ifndef SYNTH
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_blob_done |-> out_run_last) else $error("blob_done without run_last");
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !out_blob_done |-> out_status == ST_OK) else $error("status on non-final result");
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !out_byte_valid |-> out_byte == 8'd0) else $error("byte without valid");
`endif

endmodule
